/* hw/rtl/xmodem_receiver_assert.svh */
// assertion macros for the xmodem receiver
`ifndef XMODEM_RECEIVER_ASSERT_SVH
`define XMODEM_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS

// property that must hold at every edge outside reset
`define XMR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent this cycle, consequent on the next edge
`define XMR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define XMR_ASSERT(lbl, clk, rst_n, prop, msg)
`define XMR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* hw/rtl/xmr_pkg.sv */
`default_nettype none

package xmr_pkg;

    // protocol bytes
    localparam logic [7:0] B_SOH    = 8'h01;
    localparam logic [7:0] B_STX    = 8'h02;
    localparam logic [7:0] B_EOT    = 8'h04;
    localparam logic [7:0] B_ACK    = 8'h06;
    localparam logic [7:0] B_NAK    = 8'h15;
    localparam logic [7:0] B_CAN    = 8'h18;
    localparam logic [7:0] B_CRCREQ = 8'h43;

    localparam logic [10:0] SMALL_SIZE  = 11'd128;
    localparam logic [10:0] LARGE_SIZE  = 11'd1024;
    localparam logic [7:0]  RETRY_RESET = 8'd16;
    localparam logic [15:0] CRC_POLY    = 16'h1021;

    // configuration register indexes
    localparam logic [3:0] CFG_CRC_MODE    = 4'd0;
    localparam logic [3:0] CFG_MAX_RETRIES = 4'd1;

    // status codes
    localparam logic [2:0] ST_BUSY    = 3'd0;
    localparam logic [2:0] ST_ACCEPT  = 3'd1;
    localparam logic [2:0] ST_REJECT  = 3'd2;
    localparam logic [2:0] ST_DONE    = 3'd3;
    localparam logic [2:0] ST_CANCEL  = 3'd4;
    localparam logic [2:0] ST_SYNC    = 3'd5;
    localparam logic [2:0] ST_RETRIES = 3'd6;
    localparam logic [2:0] ST_IGNORED = 3'd7;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_HEADER = 4'b0010,
        PH_BLOCK  = 4'b0100,
        PH_ENDED  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [9:0] payload_index;
        logic [2:0] status;
        logic       last;
    } t_res;

    // results caused by one word: the first, then repeats of next_tx
    typedef struct packed {
        t_res       first;
        logic [7:0] next_tx;
        logic [1:0] count;
    } t_bundle;

    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/xmodem_receiver.sv */
// xmodem receiver, crc-16 or checksum blocks of 128 or 1024 bytes
// input channel: one word per received byte (cmd 1) or a start command
// (cmd 0) on i_item_valid / o_item_ready; accepted when both are high
// output channel: result words on o_res_valid / i_res_ready; each input
// word gives one result, a refused block two while on block 1 and a
// failed block three (last marks the final one)
// config channel: i_cfg_valid with i_cfg_index / i_cfg_data, always ready;
// index 0 crc_mode, 1 max_retries; write only while no word is in flight
// latency: a result is shown in the cycle after its word is accepted
// throughput: one word per cycle while results are taken every cycle; the
// output register holds one word's results, so a word with two or three
// results holds the input until its final result is taken
// if the receiver stalls, results wait in the output register and the
// input stays ready only until that register is full
// reset (synchronous, active low) ends any session: crc_mode 1,
// max_retries 16, idle until a start command, output register empty
`default_nettype none

`include "xmodem_receiver_assert.svh"

module xmodem_receiver (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire  [3:0]      i_cfg_index,
    input  wire  [7:0]      i_cfg_data,
    input  wire             i_item_valid,
    output logic            o_item_ready,
    input  xmr_pkg::t_item  i_item,
    output logic            o_res_valid,
    input  wire             i_res_ready,
    output xmr_pkg::t_res   o_res
);
    import xmr_pkg::*;

    t_bundle bundle;
    logic    take;
    logic    free;

    assign o_cfg_ready  = 1'b1;
    assign o_item_ready = free;
    assign take         = i_item_valid && free;

    xmr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_take      (take),
        .i_item      (i_item),
        .o_bundle    (bundle)
    );

    xmr_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take),
        .i_bundle (bundle),
        .o_free   (free),
        .o_valid  (o_res_valid),
        .i_ready  (i_res_ready),
        .o_res    (o_res)
    );

    // a word with more results to come blocks new input
    `XMR_ASSERT(a_hold_multi, i_clk, i_rst_n, !(o_res_valid && !o_res.last && o_item_ready), "input taken mid bundle")
    // after a non-final word leaves, the next one follows at once
    `XMR_ASSERT_NEXT(a_bundle_cont, i_clk, i_rst_n, o_res_valid && i_res_ready && !o_res.last, o_res_valid, "bundle cut short")
    // an idle tx byte field is zero
    `XMR_ASSERT(a_tx_zero, i_clk, i_rst_n, !o_res_valid || o_res.tx_valid || o_res.tx_byte == 8'h00, "tx byte without tx_valid")
    // a result is either a reply or a data byte, never both
    `XMR_ASSERT(a_excl, i_clk, i_rst_n, !(o_res_valid && o_res.tx_valid && o_res.payload_valid), "reply and payload together")

endmodule

`default_nettype wire

/* hw/rtl/xmr_core.sv */
`default_nettype none

module xmr_core (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire  [3:0]        i_cfg_index,
    input  wire  [7:0]        i_cfg_data,
    input  wire               i_take,
    input  xmr_pkg::t_item    i_item,
    output xmr_pkg::t_bundle  o_bundle
);
    import xmr_pkg::*;

    logic        r_crc_mode;
    logic [7:0]  r_max_retries;
    t_phase      r_phase, n_phase;
    logic        r_large, n_large;
    logic [10:0] r_count, n_count;
    logic [7:0]  r_expected, n_expected;
    logic [7:0]  r_retries, n_retries;
    logic [7:0]  r_rx_num, n_rx_num;
    logic [7:0]  r_rx_inv, n_rx_inv;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_sum, n_sum;
    logic [15:0] r_check, n_check;

    logic [10:0] limit;
    logic [10:0] needed;
    logic [7:0]  request;
    logic [15:0] check_now;
    logic        ok;
    t_bundle     bun;

    assign request   = r_crc_mode ? B_CRCREQ : B_NAK;
    assign limit     = (r_large ? LARGE_SIZE : SMALL_SIZE) + 11'd2;
    assign needed    = limit + (r_crc_mode ? 11'd2 : 11'd1);
    assign check_now = {r_check[7:0], i_item.rx_byte};

    always_comb begin
        ok = (r_rx_num == r_expected) && (r_rx_num == ~r_rx_inv);
        if (r_crc_mode) begin
            ok = ok && (check_now == r_crc);
        end else begin
            ok = ok && (i_item.rx_byte == r_sum);
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_large    = r_large;
        n_count    = r_count;
        n_expected = r_expected;
        n_retries  = r_retries;
        n_rx_num   = r_rx_num;
        n_rx_inv   = r_rx_inv;
        n_crc      = r_crc;
        n_sum      = r_sum;
        n_check    = r_check;
        bun        = '0;
        bun.count  = 2'd1;
        bun.first.status = ST_BUSY;

        if (!i_item.cmd) begin
            n_expected = 8'd1;
            n_retries  = r_max_retries;
            n_count    = '0;
            n_phase    = PH_HEADER;
            bun.first.tx_valid = 1'b1;
            bun.first.tx_byte  = request;
        end else begin
            case (r_phase)
                PH_HEADER: begin
                    if (i_item.rx_byte == B_SOH || i_item.rx_byte == B_STX) begin
                        n_large = (i_item.rx_byte == B_STX);
                        n_count = '0;
                        n_crc   = '0;
                        n_sum   = '0;
                        n_check = '0;
                        n_phase = PH_BLOCK;
                    end else if (i_item.rx_byte == B_EOT) begin
                        n_phase = PH_ENDED;
                        bun.first.tx_valid = 1'b1;
                        bun.first.tx_byte  = B_ACK;
                        bun.first.status   = ST_DONE;
                    end else if (i_item.rx_byte == B_CAN) begin
                        n_phase = PH_ENDED;
                        bun.first.tx_valid = 1'b1;
                        bun.first.tx_byte  = B_ACK;
                        bun.first.status   = ST_CANCEL;
                    end else begin
                        n_phase = PH_ENDED;
                        bun.first.status = ST_SYNC;
                    end
                end
                PH_BLOCK: begin
                    n_count = r_count + 11'd1;
                    if (r_count == 11'd0) begin
                        n_rx_num = i_item.rx_byte;
                    end else if (r_count == 11'd1) begin
                        n_rx_inv = i_item.rx_byte;
                    end else if (r_count < limit) begin
                        n_crc = crc_update(r_crc, i_item.rx_byte);
                        n_sum = r_sum + i_item.rx_byte;
                        bun.first.payload_valid = 1'b1;
                        bun.first.payload_byte  = i_item.rx_byte;
                        bun.first.payload_index = r_count[9:0] - 10'd2;
                    end else begin
                        n_check = check_now;
                    end

                    // final check byte: the verdict replaces the byte's own result
                    if (n_count >= needed) begin
                        bun.first = '0;
                        bun.first.tx_valid = 1'b1;
                        if (ok) begin
                            n_expected = r_expected + 8'd1;
                            n_retries  = r_max_retries;
                            n_phase    = PH_HEADER;
                            bun.first.tx_byte = B_ACK;
                            bun.first.status  = ST_ACCEPT;
                        end else if (r_retries != 8'd0) begin
                            n_retries = r_retries - 8'd1;
                            n_phase   = PH_HEADER;
                            bun.first.tx_byte = B_NAK;
                            bun.first.status  = ST_REJECT;
                            bun.next_tx = request;
                            bun.count   = (r_expected == 8'd1) ? 2'd2 : 2'd1;
                        end else begin
                            n_phase = PH_ENDED;
                            bun.first.tx_byte = B_CAN;
                            bun.first.status  = ST_RETRIES;
                            bun.next_tx = B_CAN;
                            bun.count   = 2'd3;
                        end
                    end
                end
                default: begin
                    bun.first.status = ST_IGNORED;
                end
            endcase
        end
    end

    assign o_bundle = bun;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_mode    <= 1'b1;
            r_max_retries <= RETRY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CRC_MODE:    r_crc_mode    <= i_cfg_data[0];
                CFG_MAX_RETRIES: r_max_retries <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_large    <= 1'b0;
            r_count    <= '0;
            r_expected <= 8'd1;
            r_retries  <= RETRY_RESET;
            r_rx_num   <= '0;
            r_rx_inv   <= '0;
            r_crc      <= '0;
            r_sum      <= '0;
            r_check    <= '0;
        end else if (i_take) begin
            r_phase    <= n_phase;
            r_large    <= n_large;
            r_count    <= n_count;
            r_expected <= n_expected;
            r_retries  <= n_retries;
            r_rx_num   <= n_rx_num;
            r_rx_inv   <= n_rx_inv;
            r_crc      <= n_crc;
            r_sum      <= n_sum;
            r_check    <= n_check;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/xmr_outq.sv */
`default_nettype none

module xmr_outq (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_load,
    input  xmr_pkg::t_bundle  i_bundle,
    output logic              o_free,
    output logic              o_valid,
    input  wire               i_ready,
    output xmr_pkg::t_res     o_res
);
    import xmr_pkg::*;

    logic       r_valid;
    t_res       r_res;
    logic [7:0] r_next_tx;
    logic [1:0] r_cnt;
    logic       take;

    assign take    = r_valid && i_ready;
    // room for a new bundle once the final word of this one leaves
    assign o_free  = !r_valid || (take && r_cnt == 2'd1);
    assign o_valid = r_valid;

    always_comb begin
        o_res      = r_res;
        o_res.last = (r_cnt == 2'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= 2'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_cnt   <= i_bundle.count;
        end else if (take) begin
            if (r_cnt == 2'd1) begin
                r_valid <= 1'b0;
            end
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res     <= i_bundle.first;
            r_next_tx <= i_bundle.next_tx;
        end else if (take) begin
            r_res.tx_byte <= r_next_tx;
        end
    end

endmodule

`default_nettype wire
